[hw/rtl/sise_pkg.sv]
// ----------------------------------------------------------------------------
// sise_pkg
// Shared types and codes of the sorted integer set engine.
// ----------------------------------------------------------------------------
package sise_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   localparam int VALUE_W          = 64;
   localparam int INDEX_W          = 10;
   localparam int POS_W            = 11;
   localparam int CNT_W            = 11;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_FIND   = 2'd2,
      REQ_READ   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CLS_16 = 2'd0,
      CLS_32 = 2'd1,
      CLS_64 = 2'd2
   } width_class_type;

   typedef struct packed {
      logic            eq;
      logic            lt;
      width_class_type cls;
   } cmp_res_type;

endpackage

[hw/rtl/sise_mem.sv]
// ----------------------------------------------------------------------------
// sise_mem
// Entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sise_mem #(
   parameter int DEPTH = sise_pkg::CAPACITY_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [sise_pkg::VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]                rd_addr,
   output logic [sise_pkg::VALUE_W-1:0] rd_data
);

   logic [sise_pkg::VALUE_W-1:0] entries_ff [DEPTH];
   logic [sise_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sise_cmp.sv]
// ----------------------------------------------------------------------------
// sise_cmp
// Shared compare unit: signed order of a stored entry against the key,
// plus the width class of the key.
// ----------------------------------------------------------------------------
module sise_cmp (
   input  logic [sise_pkg::VALUE_W-1:0] entry,
   input  logic [sise_pkg::VALUE_W-1:0] key,
   output sise_pkg::cmp_res_type        res
);

   logic fits16;
   logic fits32;

   assign fits16 = (&key[63:15]) | ~(|key[63:15]);
   assign fits32 = (&key[63:31]) | ~(|key[63:31]);

   always_comb begin
      res.eq = (entry == key);
      res.lt = ($signed(entry) < $signed(key));
      priority if (fits16) begin
         res.cls = sise_pkg::CLS_16;
      end else if (fits32) begin
         res.cls = sise_pkg::CLS_32;
      end else begin
         res.cls = sise_pkg::CLS_64;
      end
   end

endmodule

[hw/rtl/sorted_integer_set_engine.sv]
// ----------------------------------------------------------------------------
// sorted_integer_set_engine
// Ascending, duplicate-free set of signed 64-bit integers with width class.
// ----------------------------------------------------------------------------
// One request at a time; busy stays high from the accepting edge until the
// result strobe. A read at index reads the store and waits for the
// registered data; an index out of range goes straight to the result.
// Every other request first binary-searches the store, one probe per pass
// through S_SRCH and S_CMP. Insert then moves every entry above the
// insertion point up and remove every entry above the match down, one
// read and then one write of the store per moved word. The result is on
// the rsp_ ports for exactly one cycle with rsp_valid high; the receiver
// cannot stall it. No clearing pass after reset: only entries below the
// count are ever used.
// ----------------------------------------------------------------------------
module sorted_integer_set_engine #(
   parameter int CAPACITY = sise_pkg::CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_type,
   input  logic [sise_pkg::VALUE_W-1:0] req_value,
   input  logic [sise_pkg::INDEX_W-1:0] req_index,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [sise_pkg::VALUE_W-1:0] rsp_entry_value,
   output logic [sise_pkg::POS_W-1:0]   rsp_position,
   output logic [sise_pkg::CNT_W-1:0]   rsp_count,
   output logic [1:0]                   rsp_width_class
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_SRCH    = 10'b00_0000_0010,
      S_CMP     = 10'b00_0000_0100,
      S_ACT     = 10'b00_0000_1000,
      S_UP_RD   = 10'b00_0001_0000,
      S_UP_WR   = 10'b00_0010_0000,
      S_DN_RD   = 10'b00_0100_0000,
      S_DN_WR   = 10'b00_1000_0000,
      S_RD_WAIT = 10'b01_0000_0000,
      S_DONE    = 10'b10_0000_0000
   } state_type;

   state_type                       state_ff, state_in;
   sise_pkg::req_code_type          req_ff, req_in;
   logic [sise_pkg::VALUE_W-1:0]    value_ff, value_in;
   logic [CW-1:0]                   lo_ff, lo_in;
   logic [CW-1:0]                   hi_ff, hi_in;
   logic [CW-1:0]                   mid_ff, mid_in;
   logic [CW-1:0]                   ptr_ff, ptr_in;
   logic [CW-1:0]                   pos_ff, pos_in;
   logic                            found_ff, found_in;
   logic [CW-1:0]                   count_ff, count_in;
   sise_pkg::width_class_type       width_ff, width_in;
   sise_pkg::status_type            status_ff, status_in;
   logic [sise_pkg::VALUE_W-1:0]    ev_ff, ev_in;

   logic [CW:0]                     mid_sum;
   logic [CW-1:0]                   mid_calc;
   logic [CW-1:0]                   ptr_dec;
   logic [CW:0]                     ptr_inc;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [sise_pkg::VALUE_W-1:0]    wr_data;
   logic [AW-1:0]                   rd_addr;
   logic [sise_pkg::VALUE_W-1:0]    rd_data;
   sise_pkg::cmp_res_type           cmp;

   sise_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sise_cmp u_cmp (
      .entry (rd_data),
      .key   (value_ff),
      .res   (cmp)
   );

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[CW:1];
   assign ptr_dec  = ptr_ff - 1'b1;
   assign ptr_inc  = {1'b0, ptr_ff} + 1'b1;

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      value_in  = value_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      count_in  = count_ff;
      width_in  = width_ff;
      status_in = status_ff;
      ev_in     = ev_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff[AW-1:0];
      wr_data   = rd_data;
      rd_addr   = mid_calc[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in    = sise_pkg::req_code_type'(req_type);
               value_in  = req_value;
               lo_in     = '0;
               hi_in     = count_ff;
               pos_in    = '0;
               ev_in     = '0;
               status_in = sise_pkg::ST_DONE;
               rd_addr   = AW'(req_index);
               if (sise_pkg::req_code_type'(req_type) == sise_pkg::REQ_READ) begin
                  if (32'(req_index) < 32'(count_ff)) begin
                     state_in = S_RD_WAIT;
                  end else begin
                     status_in = sise_pkg::ST_RANGE;
                     state_in  = S_DONE;
                  end
               end else begin
                  state_in = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               state_in = S_CMP;
            end else begin
               found_in = 1'b0;
               pos_in   = lo_ff;
               state_in = S_ACT;
            end
         end
         S_CMP: begin
            priority if (cmp.eq) begin
               found_in = 1'b1;
               pos_in   = mid_ff;
               state_in = S_ACT;
            end else if (cmp.lt) begin
               lo_in    = mid_ff + 1'b1;
               state_in = S_SRCH;
            end else begin
               hi_in    = mid_ff;
               state_in = S_SRCH;
            end
         end
         S_ACT: begin
            state_in = S_DONE;
            unique case (req_ff)
               sise_pkg::REQ_INSERT: begin
                  priority if (found_ff) begin
                     status_in = sise_pkg::ST_MISS;
                  end else if (count_ff >= CW'(CAPACITY)) begin
                     status_in = sise_pkg::ST_FULL;
                  end else begin
                     ptr_in   = count_ff;
                     state_in = S_UP_RD;
                  end
               end
               sise_pkg::REQ_REMOVE: begin
                  if (!found_ff) begin
                     status_in = sise_pkg::ST_MISS;
                  end else begin
                     ptr_in   = pos_ff;
                     state_in = S_DN_RD;
                  end
               end
               sise_pkg::REQ_FIND: begin
                  status_in = found_ff ? sise_pkg::ST_DONE : sise_pkg::ST_MISS;
               end
               default: begin
                  status_in = sise_pkg::ST_DONE;
               end
            endcase
         end
         S_UP_RD: begin
            if (ptr_ff > pos_ff) begin
               rd_addr  = ptr_dec[AW-1:0];
               state_in = S_UP_WR;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[AW-1:0];
               wr_data  = value_ff;
               count_in = count_ff + 1'b1;
               if (cmp.cls > width_ff) begin
                  width_in = cmp.cls;
               end
               state_in = S_DONE;
            end
         end
         S_UP_WR: begin
            wr_en    = 1'b1;
            ptr_in   = ptr_dec;
            state_in = S_UP_RD;
         end
         S_DN_RD: begin
            if (ptr_inc < {1'b0, count_ff}) begin
               rd_addr  = ptr_inc[AW-1:0];
               state_in = S_DN_WR;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_DN_WR: begin
            wr_en    = 1'b1;
            ptr_in   = ptr_inc[CW-1:0];
            state_in = S_DN_RD;
         end
         S_RD_WAIT: begin
            ev_in    = rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         width_ff <= sise_pkg::CLS_16;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         width_ff <= width_in;
      end
      req_ff    <= req_in;
      value_ff  <= value_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      ev_ff     <= ev_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_DONE);
   assign rsp_status      = status_ff;
   assign rsp_entry_value = ev_ff;
   assign rsp_position    = sise_pkg::POS_W'(pos_ff);
   assign rsp_count       = sise_pkg::CNT_W'(count_ff);
   assign rsp_width_class = width_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_class_monotone: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> width_ff >= $past(width_ff))
      else $error("width class narrowed");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status_ff == sise_pkg::ST_FULL |-> count_ff == CW'(CAPACITY))
      else $error("store full reported below capacity");

endmodule

[verif/tb_sorted_integer_set_engine.sv]
// ----------------------------------------------------------------------------
// tb_sorted_integer_set_engine
// Self-checking bench for the sorted integer set engine. A short table of
// directed requests covers an empty store, duplicates, misses, every width
// class step and both value extremes. Random traffic follows: mixed requests
// on a small set, a drain, an ascending fill with duplicate and miss probes,
// then mixed requests on the filled set. Every word is checked field by
// field against its typed reply or a behavioral model of the set kept here.
// ----------------------------------------------------------------------------
module tb_sorted_integer_set_engine;

   localparam int SET_CAP     = sise_pkg::CAPACITY_DEFAULT;
   localparam int FILL_COUNT  = 60;
   localparam int QUIET_LIMIT = 20000;

   localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [63:0] BOUNDARY_VALS [12] = '{
      64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h7FFF, 64'h8000, 64'hFFFF_FFFF_FFFF_8000, 64'hFFFF_FFFF_FFFF_7FFF,
      64'h7FFF_FFFF, 64'h8000_0000, 64'hFFFF_FFFF_8000_0000,
      64'hFFFF_FFFF_7FFF_FFFF, VAL_MAX, VAL_MIN
   };

   localparam int GAP_CHOICES [3] = '{0, 15, 45};

   typedef struct packed {
      sise_pkg::status_type            status;
      logic [63:0]                     entry;
      logic [sise_pkg::POS_W-1:0]      pos;
      logic [sise_pkg::CNT_W-1:0]      cnt;
      sise_pkg::width_class_type       cls;
   } set_reply_type;

   localparam set_reply_type NO_REPLY =
      '{sise_pkg::ST_DONE, 64'd0, 11'd0, 11'd0, sise_pkg::CLS_16};

   typedef struct {
      sise_pkg::req_code_type op;
      logic [63:0]            value;
      logic [9:0]             index;
      bit                     typed;
      set_reply_type          want;
   } dir_row_type;

   // typed rows carry a hand-written reply; the rest use the model
   dir_row_type dir_rows [24] = '{
      '{sise_pkg::REQ_READ,   64'd0,   10'd0,    1'b1,
        '{sise_pkg::ST_RANGE, 64'd0, 11'd0, 11'd0, sise_pkg::CLS_16}},
      '{sise_pkg::REQ_FIND,   64'd0,   10'd0,    1'b1,
        '{sise_pkg::ST_MISS,  64'd0, 11'd0, 11'd0, sise_pkg::CLS_16}},
      '{sise_pkg::REQ_REMOVE, 64'd5,   10'd0,    1'b1,
        '{sise_pkg::ST_MISS,  64'd0, 11'd0, 11'd0, sise_pkg::CLS_16}},
      '{sise_pkg::REQ_INSERT, 64'd100, 10'd0,    1'b1,
        '{sise_pkg::ST_DONE,  64'd0, 11'd0, 11'd1, sise_pkg::CLS_16}},
      '{sise_pkg::REQ_INSERT, 64'd100, 10'd0,    1'b1,
        '{sise_pkg::ST_MISS,  64'd0, 11'd0, 11'd1, sise_pkg::CLS_16}},
      '{sise_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_8000, 10'd0, 1'b0, NO_REPLY},
      '{sise_pkg::REQ_INSERT, 64'h7FFF,                10'd0, 1'b0, NO_REPLY},
      '{sise_pkg::REQ_INSERT, 64'h8000,                10'd0, 1'b0, NO_REPLY},
      '{sise_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_7FFF, 10'd0, 1'b0, NO_REPLY},
      '{sise_pkg::REQ_INSERT, 64'h7FFF_FFFF,           10'd0, 1'b0, NO_REPLY},
      '{sise_pkg::REQ_INSERT, 64'hFFFF_FFFF_8000_0000, 10'd0, 1'b0, NO_REPLY},
      '{sise_pkg::REQ_INSERT, 64'h8000_0000,           10'd0, 1'b0, NO_REPLY},
      '{sise_pkg::REQ_INSERT, VAL_MIN,                 10'd0, 1'b0, NO_REPLY},
      '{sise_pkg::REQ_INSERT, VAL_MAX,                 10'd0, 1'b0, NO_REPLY},
      '{sise_pkg::REQ_READ,   64'd0,   10'd0,    1'b1,
        '{sise_pkg::ST_DONE,  VAL_MIN, 11'd0, 11'd10, sise_pkg::CLS_64}},
      '{sise_pkg::REQ_READ,   64'd0,   10'd9,    1'b1,
        '{sise_pkg::ST_DONE,  VAL_MAX, 11'd0, 11'd10, sise_pkg::CLS_64}},
      '{sise_pkg::REQ_READ,   64'd0,   10'd10,   1'b1,
        '{sise_pkg::ST_RANGE, 64'd0,   11'd0, 11'd10, sise_pkg::CLS_64}},
      '{sise_pkg::REQ_READ,   VAL_MAX, 10'd1023, 1'b1,
        '{sise_pkg::ST_RANGE, 64'd0,   11'd0, 11'd10, sise_pkg::CLS_64}},
      '{sise_pkg::REQ_FIND,   64'd100, 10'd0,    1'b0, NO_REPLY},
      '{sise_pkg::REQ_FIND,   64'd101, 10'd0,    1'b1,
        '{sise_pkg::ST_MISS,  64'd0,   11'd5, 11'd10, sise_pkg::CLS_64}},
      '{sise_pkg::REQ_REMOVE, 64'd100, 10'd0,    1'b0, NO_REPLY},
      '{sise_pkg::REQ_REMOVE, VAL_MIN, 10'd0,    1'b0, NO_REPLY},
      '{sise_pkg::REQ_REMOVE, VAL_MAX, 10'd0,    1'b0, NO_REPLY},
      '{sise_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0, 1'b0, NO_REPLY}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic [1:0]                     req_type = sise_pkg::REQ_INSERT;
   logic [sise_pkg::VALUE_W-1:0]   req_value = '0;
   logic [sise_pkg::INDEX_W-1:0]   req_index = '0;
   logic                           busy;
   logic                           rsp_valid;
   logic [1:0]                     rsp_status;
   logic [sise_pkg::VALUE_W-1:0]   rsp_entry_value;
   logic [sise_pkg::POS_W-1:0]     rsp_position;
   logic [sise_pkg::CNT_W-1:0]     rsp_count;
   logic [1:0]                     rsp_width_class;

   // model of the set contents
   logic [63:0]                    set_mem [SET_CAP];
   int                             set_count = 0;
   sise_pkg::width_class_type      set_cls = sise_pkg::CLS_16;

   set_reply_type                  pending_replies [$];
   set_reply_type                  head_reply;
   int                             error_count = 0;
   int                             quiet_cycles = 0;
   int                             gap_pct = 0;

   sorted_integer_set_engine #(
      .CAPACITY(SET_CAP)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_value(req_value),
      .req_index(req_index),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_entry_value(rsp_entry_value),
      .rsp_position(rsp_position),
      .rsp_count(rsp_count),
      .rsp_width_class(rsp_width_class)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // applies one request to the model set and returns the reply word
   function automatic set_reply_type set_next_reply(input sise_pkg::req_code_type op,
                                                    input logic [63:0] val,
                                                    input logic [9:0] idx);
      set_reply_type              r;
      int                         lo;
      int                         hi;
      int                         mid;
      bit                         hit;
      logic signed [63:0]         sval;
      sise_pkg::width_class_type  need;
      r = NO_REPLY;
      sval = val;
      if (op == sise_pkg::REQ_READ) begin
         if (int'(idx) < set_count)
            r.entry = set_mem[idx];
         else
            r.status = sise_pkg::ST_RANGE;
      end else begin
         lo = 0;
         hi = set_count;
         hit = 1'b0;
         while (lo < hi && !hit) begin
            mid = (lo + hi) >> 1;
            if (set_mem[mid] == val) begin
               hit = 1'b1;
               lo = mid;
            end else if ($signed(set_mem[mid]) < sval) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         r.pos = 11'(lo);
         case (op)
            sise_pkg::REQ_INSERT: begin
               if (hit) begin
                  r.status = sise_pkg::ST_MISS;
               end else if (set_count >= SET_CAP) begin
                  r.status = sise_pkg::ST_FULL;
               end else begin
                  for (int i = set_count; i > lo; i--)
                     set_mem[i] = set_mem[i - 1];
                  set_mem[lo] = val;
                  set_count++;
                  if (sval >= -64'sd32768 && sval <= 64'sd32767)
                     need = sise_pkg::CLS_16;
                  else if (sval >= -64'sd2147483648 && sval <= 64'sd2147483647)
                     need = sise_pkg::CLS_32;
                  else
                     need = sise_pkg::CLS_64;
                  if (need > set_cls)
                     set_cls = need;
               end
            end
            sise_pkg::REQ_REMOVE: begin
               if (!hit) begin
                  r.status = sise_pkg::ST_MISS;
               end else begin
                  for (int i = lo; i + 1 < set_count; i++)
                     set_mem[i] = set_mem[i + 1];
                  set_count--;
               end
            end
            default: begin
               r.status = hit ? sise_pkg::ST_DONE : sise_pkg::ST_MISS;
            end
         endcase
      end
      r.cnt = 11'(set_count);
      r.cls = set_cls;
      return r;
   endfunction

   function automatic sise_pkg::req_code_type pick_op();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 40)
         return sise_pkg::REQ_INSERT;
      if (sel < 65)
         return sise_pkg::REQ_REMOVE;
      if (sel < 85)
         return sise_pkg::REQ_FIND;
      return sise_pkg::REQ_READ;
   endfunction

   function automatic logic [63:0] pick_value();
      int unsigned sel;
      int          near;
      sel = $urandom_range(99);
      near = int'($urandom_range(128)) - 64;
      if (sel < 30 && set_count > 0)
         return set_mem[$urandom_range(set_count - 1)];
      if (sel < 60)
         return 64'(near);
      if (sel < 75)
         return BOUNDARY_VALS[$urandom_range(11)];
      return {$urandom, $urandom};
   endfunction

   function automatic logic [9:0] pick_index();
      int unsigned top;
      top = (set_count > 1023) ? 1023 : set_count;
      if ($urandom_range(9) < 7)
         return 10'($urandom_range(top));
      return 10'($urandom);
   endfunction

   // drives one word, waits for it to be taken, then maybe idles a burst
   task automatic issue_word(input sise_pkg::req_code_type op, input logic [63:0] val,
                             input logic [9:0] idx, input bit typed = 1'b0,
                             input set_reply_type want = NO_REPLY);
      set_reply_type predicted;
      start <= 1'b1;
      req_type <= op;
      req_value <= val;
      req_index <= idx;
      do
         @(posedge clock);
      while (busy);
      predicted = set_next_reply(op, val, idx);
      pending_replies.push_back(typed ? want : predicted);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic run_mixed(input int n_items, input int quiet_tail);
      for (int k = 0; k < n_items; k++) begin
         if (k >= n_items - quiet_tail)
            gap_pct = 0;
         else if (k % 40 == 0)
            gap_pct = GAP_CHOICES[$urandom_range(2)];
         issue_word(pick_op(), pick_value(), pick_index());
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (rsp_valid === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: word with none pending, expected none, actual status %0h",
                     $time, rsp_status);
            error_count++;
         end else begin
            head_reply = pending_replies.pop_front();
            check_field("status", 64'(head_reply.status), 64'(rsp_status));
            check_field("entry_value", head_reply.entry, rsp_entry_value);
            check_field("position", 64'(head_reply.pos), 64'(rsp_position));
            check_field("count", 64'(head_reply.cnt), 64'(rsp_count));
            check_field("width_class", 64'(head_reply.cls), 64'(rsp_width_class));
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_sorted_integer_set_engine: done, errors");
         $finish;
      end
   end

   initial begin
      logic [63:0] next_val;
      logic [63:0] seed_bits;
      int unsigned pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      gap_pct = 25;
      foreach (dir_rows[i])
         issue_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].index,
                    dir_rows[i].typed, dir_rows[i].want);

      run_mixed(210, 0);
      settle();

      // drain from the top, then fill in ascending order
      gap_pct = 10;
      while (set_count > 0)
         issue_word(sise_pkg::REQ_REMOVE, set_mem[set_count - 1], 10'($urandom));
      seed_bits = {$urandom, $urandom};
      next_val = {{2{seed_bits[61]}}, seed_bits[61:0]};
      while (set_count < FILL_COUNT) begin
         issue_word(sise_pkg::REQ_INSERT, next_val, 10'($urandom));
         next_val = next_val + 64'($urandom_range(1 << 30)) + 64'd1;
      end

      gap_pct = 20;
      issue_word(sise_pkg::REQ_INSERT, VAL_MAX, 10'd0);
      issue_word(sise_pkg::REQ_FIND, VAL_MAX, 10'd0);
      issue_word(sise_pkg::REQ_READ, 64'd0, 10'd1023);
      repeat (8) begin
         pick = $urandom_range(set_count - 1);
         next_val = set_mem[pick];
         issue_word(sise_pkg::REQ_INSERT, {$urandom, $urandom}, 10'($urandom));
         issue_word(sise_pkg::REQ_INSERT, next_val, 10'($urandom));
         issue_word(sise_pkg::REQ_READ, {$urandom, $urandom}, 10'($urandom));
         issue_word(sise_pkg::REQ_REMOVE, next_val, 10'($urandom));
         issue_word(sise_pkg::REQ_FIND, next_val, 10'($urandom));
         issue_word(sise_pkg::REQ_INSERT, next_val, 10'($urandom));
      end

      run_mixed(180, 60);
      settle();
      repeat (40) @(posedge clock);

      if (error_count == 0 && pending_replies.size() == 0)
         $display("tb_sorted_integer_set_engine: done, clean");
      else
         $display("tb_sorted_integer_set_engine: done, errors");
      $finish;
   end

endmodule
